/* rtl/sha512_stream_hasher_unit_defines.svh */
// Assertion macros shared by the hasher RTL.
`ifndef SHA512_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA512_STREAM_HASHER_UNIT_DEFINES_SVH

// Implication checked every clock, held off during reset.
`define SHS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked every clock, held off during reset.
`define SHS_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* rtl/shs_pkg.sv */
`timescale 1ns / 1ps
package shs_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumWords = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [6:0] round_t;
  typedef logic [3:0] widx_t;

  // Word source for the block buffer write
  typedef enum logic [2:0] {
    WSRC_MSG,
    WSRC_PAD,
    WSRC_ONE,
    WSRC_ZERO,
    WSRC_LEN_HI,
    WSRC_LEN_LO
  } wsrc_e;

  typedef struct packed {
    logic  in_take;
    logic  wr_en;
    wsrc_e wr_src;
    logic  idx_inc;
    logic  idx_clr;
    logic  comp_start;
    logic  round_en;
    logic  comp_end;
    logic  hash_init;
    logic  out_valid;
    logic  out_last;
    logic  out_shift;
  } cmd_t;

  typedef struct packed {
    widx_t  idx;
    round_t round;
    logic [2:0] out_cnt;
  } sts_t;

  localparam word_t K [NumRounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

/* rtl/shs_if.sv */
`timescale 1ns / 1ps
interface shs_msg_if;
  logic                valid;
  logic                ready;
  shs_pkg::word_t      msg_word;
  logic [3:0]          byte_count;
  logic                last_word;
  modport source (output valid, msg_word, byte_count, last_word, input ready);
  modport sink (input valid, msg_word, byte_count, last_word, output ready);
endinterface

interface shs_dig_if;
  logic           valid;
  logic           ready;
  shs_pkg::word_t digest_word;
  logic           digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

/* rtl/sha512_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// channel  | dir | payload
// msg      | in  | msg_word, byte_count, last_word
// digest   | out | digest_word, digest_last
// A word is taken only while the unit is idle; the 16th word of a block starts 80
// rounds, after which the result is folded into the hash.
// The last word adds padding words, one or two compressions and
// eight digest items, one per cycle while the sink is ready.
// Reset (rst_ni low) restores the initial hash and clears the length.
// The digest holds while ready is low; no item is taken meanwhile.
module sha512_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  shs_msg_if.sink     msg_i,
  shs_dig_if.source   dig_o
);

  shs_pkg::cmd_t cmd;
  shs_pkg::sts_t sts, sts_c;

  // out_cnt is only the digest counter once output starts; passed to control unmasked
  assign sts_c.idx     = sts.idx;
  assign sts_c.round   = sts.round;
  assign sts_c.out_cnt = sts.out_cnt;

  shs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .in_last_i   (msg_i.last_word),
    .in_count_i  (msg_i.byte_count),
    .out_ready_i (dig_o.ready),
    .sts_i       (sts_c),
    .in_ready_o  (msg_i.ready),
    .cmd_o       (cmd)
  );

  shs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_word_i    (msg_i.msg_word),
    .byte_count_i  (msg_i.byte_count),
    .last_word_i   (msg_i.last_word),
    .sts_o         (sts),
    .digest_word_o (dig_o.digest_word)
  );

  assign dig_o.valid       = cmd.out_valid;
  assign dig_o.digest_last = cmd.out_last;

endmodule

/* rtl/shs_ctrl.sv */
`timescale 1ns / 1ps
`include "sha512_stream_hasher_unit_defines.svh"
module shs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  input  logic [3:0]      in_count_i,
  input  logic            out_ready_i,
  input  shs_pkg::sts_t   sts_i,
  output logic            in_ready_o,
  output shs_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StComp  = 3'd1;
  localparam logic [2:0] StOne   = 3'd2;
  localparam logic [2:0] StZero  = 3'd3;
  localparam logic [2:0] StLenHi = 3'd4;
  localparam logic [2:0] StLenLo = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;
  localparam logic [2:0] StFold  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       fin_q, fin_d;   // last word taken: padding or digest output in progress
  logic       one_q, one_d;   // 0x80 word still owed
  logic [3:0] nsat;

  assign nsat = (in_count_i > 4'd8) ? 4'd8 : in_count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
      one_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      one_q   <= one_d;
    end
  end

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    one_d   = one_q;
    cmd_o   = '0;
    cmd_o.wr_src = shs_pkg::WSRC_MSG;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          cmd_o.wr_en   = 1'b1;
          cmd_o.idx_inc = 1'b1;
          cmd_o.wr_src  = in_last_i ? shs_pkg::WSRC_PAD : shs_pkg::WSRC_MSG;
          if (in_last_i) begin
            fin_d = 1'b1;
            one_d = (nsat == 4'd8);
          end
          if (sts_i.idx == 4'd15) begin
            cmd_o.comp_start = 1'b1;
            state_d = StComp;
          end else if (in_last_i) begin
            state_d = (nsat == 4'd8) ? StOne : StZero;
          end
        end
      end
      StComp: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round == 7'(shs_pkg::NumRounds - 1)) begin
          state_d = StFold;
        end
      end
      StFold: begin
        cmd_o.comp_end = 1'b1;
        cmd_o.idx_clr  = 1'b1;
        if (!fin_q) state_d = StIdle;
        else if (one_q) state_d = StOne;
        else if (sts_i.idx == 4'd0 && !one_q && fin_q && sts_i.out_cnt == 3'd1)
          state_d = StOut;
        else state_d = StZero;
      end
      StOne: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = shs_pkg::WSRC_ONE;
        cmd_o.idx_inc = 1'b1;
        one_d = 1'b0;
        if (sts_i.idx == 4'd15) begin
          cmd_o.comp_start = 1'b1;
          state_d = StComp;
        end else begin
          state_d = StZero;
        end
      end
      StZero: begin
        if (sts_i.idx == 4'd14) begin
          state_d = StLenHi;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_src  = shs_pkg::WSRC_ZERO;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx == 4'd15) begin
            cmd_o.comp_start = 1'b1;
            state_d = StComp;
          end
        end
      end
      StLenHi: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = shs_pkg::WSRC_LEN_HI;
        cmd_o.idx_inc = 1'b1;
        state_d = StLenLo;
      end
      StLenLo: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_src     = shs_pkg::WSRC_LEN_LO;
        cmd_o.idx_inc    = 1'b1;
        cmd_o.comp_start = 1'b1;
        cmd_o.out_last   = 1'b1;
        state_d = StComp;
      end
      StOut: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.out_last  = (sts_i.out_cnt == 3'd7);
        if (out_ready_i) begin
          cmd_o.out_shift = 1'b1;
          if (sts_i.out_cnt == 3'd7) begin
            cmd_o.hash_init = 1'b1;
            fin_d   = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  `SHS_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == StIdle)
  `SHS_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, state_q == StComp, !cmd_o.in_take)
  `SHS_ASSERT_NXT(a_start_comp, clk_i, rst_ni, cmd_o.comp_start, state_q == StComp)

endmodule

/* rtl/shs_dp.sv */
`timescale 1ns / 1ps
`include "sha512_stream_hasher_unit_defines.svh"
module shs_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shs_pkg::cmd_t   cmd_i,
  input  shs_pkg::word_t  msg_word_i,
  input  logic [3:0]      byte_count_i,
  input  logic            last_word_i,
  output shs_pkg::sts_t   sts_o,
  output shs_pkg::word_t  digest_word_o
);

  shs_pkg::word_t win_q [shs_pkg::NumWords];
  shs_pkg::word_t var_q [8];
  shs_pkg::word_t hash_q [8];
  logic [127:0]   len_q;
  shs_pkg::widx_t idx_q;
  shs_pkg::round_t round_q;
  logic [2:0]     out_q;  // 1 marks the final compression started and its digest not yet sent
  logic [2:0]     ocnt_q;
  logic           pend_q;

  logic [3:0]     nsat;
  shs_pkg::word_t pad_w, wr_w, wt, s0, s1, t1, t2;
  shs_pkg::word_t mask;
  logic [6:0]     sh;
  shs_pkg::widx_t ri;

  assign nsat = !last_word_i ? 4'd8 : ((byte_count_i > 4'd8) ? 4'd8 : byte_count_i);

  always_comb begin
    sh   = 7'(64) - {nsat, 3'b000};
    mask = (nsat == 4'd0) ? '0 : ({64{1'b1}} << sh[5:0]);
    if (nsat == 4'd8) mask = {64{1'b1}};
    pad_w = msg_word_i & mask;
    if (nsat != 4'd8) pad_w = pad_w | (shs_pkg::word_t'(8'h80) << (sh[5:0] - 6'd8));
  end

  always_comb begin
    unique case (cmd_i.wr_src)
      shs_pkg::WSRC_MSG:    wr_w = msg_word_i;
      shs_pkg::WSRC_PAD:    wr_w = pad_w;
      shs_pkg::WSRC_ONE:    wr_w = 64'h8000000000000000;
      shs_pkg::WSRC_ZERO:   wr_w = '0;
      shs_pkg::WSRC_LEN_HI: wr_w = len_q[127:64];
      shs_pkg::WSRC_LEN_LO: wr_w = len_q[63:0];
      default:              wr_w = '0;
    endcase
  end

  assign ri = round_q[3:0];

  always_comb begin
    s1 = shs_pkg::rotr(win_q[ri - 4'd2], 19) ^ shs_pkg::rotr(win_q[ri - 4'd2], 61)
       ^ (win_q[ri - 4'd2] >> 6);
    s0 = shs_pkg::rotr(win_q[ri - 4'd15], 1) ^ shs_pkg::rotr(win_q[ri - 4'd15], 8)
       ^ (win_q[ri - 4'd15] >> 7);
    wt = (round_q < 7'd16) ? win_q[ri] : (s1 + win_q[ri - 4'd7] + s0 + win_q[ri]);
    t1 = var_q[7] + (shs_pkg::rotr(var_q[4], 14) ^ shs_pkg::rotr(var_q[4], 18)
       ^ shs_pkg::rotr(var_q[4], 41)) + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
       + shs_pkg::K[round_q] + wt;
    t2 = (shs_pkg::rotr(var_q[0], 28) ^ shs_pkg::rotr(var_q[0], 34)
       ^ shs_pkg::rotr(var_q[0], 39))
       + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) win_q[idx_q] <= wr_w;
    else if (cmd_i.round_en && round_q >= 7'd16) win_q[ri] <= wt;
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
    end else if (cmd_i.round_en) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= shs_pkg::IV[i];
      len_q   <= '0;
      idx_q   <= '0;
      round_q <= '0;
      pend_q  <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      if (cmd_i.in_take) len_q <= len_q + 128'({nsat, 3'b000});
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 4'd1;
      if (cmd_i.comp_end) round_q <= '0;
      else if (cmd_i.round_en)
        round_q <= (round_q == 7'(shs_pkg::NumRounds - 1)) ? '0 : round_q + 7'd1;
      if (cmd_i.comp_start && cmd_i.out_last) pend_q <= 1'b1;
      if (cmd_i.comp_end) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
      end else if (cmd_i.out_shift) begin
        if (cmd_i.hash_init) begin
          for (int i = 0; i < 8; i++) hash_q[i] <= shs_pkg::IV[i];
          len_q  <= '0;
          pend_q <= 1'b0;
          ocnt_q <= '0;
        end else begin
          for (int i = 0; i < 7; i++) hash_q[i] <= hash_q[i+1];
          hash_q[7] <= hash_q[0];
          ocnt_q <= ocnt_q + 3'd1;
        end
      end
    end
  end

  assign out_q = pend_q ? 3'd1 : 3'd0;

  assign sts_o.idx     = idx_q;
  assign sts_o.round   = round_q;
  assign sts_o.out_cnt = pend_q ? ((ocnt_q == 3'd0) ? out_q : ocnt_q) : ocnt_q;
  assign digest_word_o = hash_q[0];

  `SHS_ASSERT_IMP(a_round_rng, clk_i, rst_ni, 1'b1, round_q < 7'(shs_pkg::NumRounds))
  `SHS_ASSERT_NXT(a_round_clr, clk_i, rst_ni, cmd_i.comp_end, round_q == 7'd0)
  `SHS_ASSERT_NXT(a_idx_clr, clk_i, rst_ni, cmd_i.idx_clr, idx_q == 4'd0)

endmodule

/* tb/shs_tb_if.sv */
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (shs_msg_if, shs_dig_if); nothing to add here.
package shs_tb_pkg;
  localparam int unsigned DigestWords = 8;
endpackage

/* tb/sha512_stream_hasher_unit_tb.sv */
`timescale 1ns / 1ps
module sha512_stream_hasher_unit_tb;

  typedef shs_pkg::word_t word_t;

  typedef struct {
    word_t      digest_word;
    logic       digest_last;
  } digest_item_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 300;

  logic clk_i;
  logic rst_ni;
  shs_msg_if msg_if ();
  shs_dig_if dig_if ();

  sha512_stream_hasher_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if.sink),
    .dig_o  (dig_if.source)
  );

  word_t        hash_q [8];
  word_t        block_q [16];
  int unsigned  word_idx;
  logic [127:0] bit_len;
  digest_item_t digest_q [$];
  int unsigned  err_cnt;
  int unsigned  idle_cnt;
  int unsigned  hold_cnt;
  bit           hold_req;
  bit           hold_seen;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_blk();
    word_t v [8];
    word_t w, t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        w = block_q[t];
      end else begin
        s1 = ror(block_q[(t-2)%16], 19) ^ ror(block_q[(t-2)%16], 61) ^ (block_q[(t-2)%16] >> 6);
        s0 = ror(block_q[(t-15)%16], 1) ^ ror(block_q[(t-15)%16], 8)
           ^ (block_q[(t-15)%16] >> 7);
        w = s1 + block_q[(t-7)%16] + s0 + block_q[t%16];
        block_q[t%16] = w;
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shs_pkg::K[t] + w;
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endtask

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hash_q[i] = shs_pkg::IV[i];
    word_idx = 0;
    bit_len = '0;
  endtask

  task automatic predict_word(word_t wd, logic [3:0] cnt, logic lst);
    int unsigned n;
    word_t       pw;
    digest_item_t it;
    n = lst ? ((cnt > 8) ? 8 : cnt) : 8;
    bit_len += 128'(n * 8);
    if (!lst) begin
      block_q[word_idx++] = wd;
      if (word_idx == 16) begin
        compress_blk();
        word_idx = 0;
      end
      return;
    end
    pw = (n == 0) ? '0 : (wd & ({64{1'b1}} << (64 - 8 * n)));
    if (n < 8) pw |= word_t'(64'h80) << (56 - 8 * n);
    block_q[word_idx++] = pw;
    if (n == 8) begin
      if (word_idx == 16) begin
        compress_blk();
        word_idx = 0;
      end
      block_q[word_idx++] = 64'h8000000000000000;
    end
    if (word_idx > 14) begin
      while (word_idx < 16) block_q[word_idx++] = '0;
      compress_blk();
      word_idx = 0;
    end
    while (word_idx < 14) block_q[word_idx++] = '0;
    block_q[14] = bit_len[127:64];
    block_q[15] = bit_len[63:0];
    compress_blk();
    for (int k = 0; k < shs_tb_pkg::DigestWords; k++) begin
      it.digest_word = hash_q[k];
      it.digest_last = (k == 7);
      digest_q.push_back(it);
    end
    hash_restart();
  endtask

  task automatic report_mismatch(string what, word_t got, word_t exp_v);
    err_cnt++;
    $display("%0t mismatch %s: got %h exp %h", $realtime, what, got, exp_v);
  endtask

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_word(word_t wd, logic [3:0] cnt, logic lst, bit gaps = 1);
    int unsigned g;
    g = gaps ? rand_gap() : 0;
    if (g != 0) begin
      msg_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    msg_if.valid      <= 1'b1;
    msg_if.msg_word   <= wd;
    msg_if.byte_count <= cnt;
    msg_if.last_word  <= lst;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    predict_word(wd, cnt, lst);
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // message of nwords full words then a last word with cnt bytes
  task automatic send_msg(int unsigned nwords, logic [3:0] cnt, bit gaps = 1);
    for (int i = 0; i < nwords; i++) send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0, gaps);
    send_word(rand_word(), cnt, 1'b1, gaps);
  endtask

  task automatic wait_drain();
    msg_if.valid <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word('1, 4'd15, 1'b1);
    send_word(64'h6162630000000000, 4'd3, 1'b1);
    send_word('1, 4'd7, 1'b1);
    send_msg(13, 4'd7);
    send_msg(13, 4'd8);
    send_msg(14, 4'd0);
    send_msg(15, 4'd8);
    send_msg(15, 4'd3);
    send_msg(16, 4'd0);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < 200) begin
      if ($urandom_range(0, 7) == 0) n = $urandom_range(16, 40);
      else n = $urandom_range(0, 17);
      send_msg(n, 4'($urandom_range(0, 15)));
      sent += n + 1;
    end
  endtask

  task automatic test_backpressure();
    hold_req = ~hold_req;
    send_msg(2, 4'd5, 0);
    send_msg(20, 4'd8, 0);
    send_msg(0, 4'd2, 0);
    wait_drain();
    send_msg(3, 4'd4, 0);
  endtask

  initial begin
    msg_if.valid      = 1'b0;
    msg_if.msg_word   = '0;
    msg_if.byte_count = '0;
    msg_if.last_word  = 1'b0;
    err_cnt  = 0;
    hold_req = 1'b0;
    hash_restart();
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) $display("sha512_stream_hasher_unit_tb: clean");
    else $display("sha512_stream_hasher_unit_tb: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dig_if.ready <= 1'b0;
      hold_cnt     <= 0;
      hold_seen    <= hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_cnt     <= HoldCycles;
      dig_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      dig_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else if ($urandom_range(0, 1) == 0) begin
      dig_if.ready <= 1'b1;
    end else begin
      dig_if.ready <= ($urandom_range(0, 2) != 0) || ($urandom_range(0, 30) == 0 ? 0 : 1);
    end
  end

  always @(posedge clk_i) begin
    digest_item_t exp_it;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest item", dig_if.digest_word, '0);
      end else begin
        exp_it = digest_q.pop_front();
        if (dig_if.digest_word !== exp_it.digest_word)
          report_mismatch("digest_word", dig_if.digest_word, exp_it.digest_word);
        if (dig_if.digest_last !== exp_it.digest_last)
          report_mismatch("digest_last", word_t'(dig_if.digest_last), word_t'(exp_it.digest_last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)
        || (hold_cnt != 0)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("sha512_stream_hasher_unit_tb: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
